@@ src/ile_pkg.sv @@
// Shared types, codes and constants for the indexed list engine.
// No dependencies; ile_front, ile_back and indexed_list_engine_core import this package.
package ile_pkg;

   localparam int DEFAULT_DEPTH = 256;

   typedef enum logic [3:0] {
      OP_APPEND  = 4'd0,
      OP_INSERT  = 4'd1,
      OP_POP     = 4'd2,
      OP_CLEAR   = 4'd3,
      OP_COUNT   = 4'd4,
      OP_REVERSE = 4'd5,
      OP_LENGTH  = 4'd6,
      OP_SET     = 4'd7,
      OP_GET     = 4'd8,
      OP_ERASE   = 4'd9,
      OP_SWAP    = 4'd10,
      OP_SORT    = 4'd11,
      OP_BAD     = 4'd12
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [8:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [8:0]         list_length;
      logic [1:0]         status;
   } rsp_type;

   // Classified request handed from the front end to the back end.
   typedef struct packed {
      op_type             op;
      logic [8:0]         position;
      logic signed [31:0] value;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SH_RD,
      S_SH_WR,
      S_INS_FIN,
      S_CNT_RD,
      S_CNT_CMP,
      S_GET_WT,
      S_P_RDA,
      S_P_RDB,
      S_P_CMP,
      S_P_WRA,
      S_P_WRB,
      S_P_NEXT,
      S_DONE
   } state_type;

endpackage

@@ src/ile_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ src/ile_front.sv @@
// Front end: accepts request beats, classifies the operation code and
// holds up to two classified commands for the back end. Uses ile_pkg.
module ile_front
   import ile_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       do_push, do_pop;

   always_comb begin
      dec.position = req_data.position;
      dec.value    = req_data.value;
      unique case (req_data.operation)
         OP_APPEND:  dec.op = OP_APPEND;
         OP_INSERT:  dec.op = OP_INSERT;
         OP_POP:     dec.op = OP_POP;
         OP_CLEAR:   dec.op = OP_CLEAR;
         OP_COUNT:   dec.op = OP_COUNT;
         OP_REVERSE: dec.op = OP_REVERSE;
         OP_LENGTH:  dec.op = OP_LENGTH;
         OP_SET:     dec.op = OP_SET;
         OP_GET:     dec.op = OP_GET;
         OP_ERASE:   dec.op = OP_ERASE;
         OP_SWAP:    dec.op = OP_SWAP;
         OP_SORT:    dec.op = OP_SORT;
         default:    dec.op = OP_BAD;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = ent_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= dec;
      end
   end

endmodule

@@ src/ile_back.sv @@
// Back end: sequencer that carries out list commands on the element RAM
// and holds the finished result beat. Uses ile_pkg; drives ile_ram ports.
module ile_back
   import ile_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_take,
   output logic                     ram_we,
   output logic [$clog2(DEPTH)-1:0] ram_waddr,
   output logic [31:0]              ram_wdata,
   output logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  logic [31:0]              ram_rdata,
   output logic                     empty,
   input  logic                     pop,
   output rsp_type                  rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > 9) ? CW : 9) + 1;
   localparam logic [XW-1:0] DX = XW'(DEPTH);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CW-1:0]      n_ff, n_in, idx_ff, idx_in, b_ff, b_in, lim_ff, lim_in;
   logic [31:0]        da_ff, da_in, db_ff, db_in;
   logic signed [31:0] res_ff, res_in;
   status_type         stat_ff, stat_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic [XW-1:0] nx, px, cpx, ix, bx;

   assign nx  = XW'(n_ff);
   assign px  = XW'(cmd.position);
   assign cpx = XW'(cmd_ff.position);
   assign ix  = XW'(idx_ff);
   assign bx  = XW'(b_ff);

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      b_in         = b_ff;
      lim_in       = lim_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      cmd_take     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               res_in   = '0;
               stat_in  = ST_DONE;
               state_in = S_DONE;
               unique case (cmd.op)
                  OP_APPEND: begin
                     if (nx >= DX) begin
                        stat_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = n_ff[AW-1:0];
                        ram_wdata = cmd.value;
                        n_in      = n_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (px > nx) begin
                        stat_in = ST_IGNORED;
                     end else if (nx >= DX) begin
                        stat_in = ST_FULL;
                     end else if (px == nx) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(px);
                        ram_wdata = cmd.value;
                        n_in      = n_ff + 1'b1;
                     end else begin
                        idx_in   = n_ff;
                        state_in = S_SH_RD;
                     end
                  end
                  OP_POP: begin
                     if (n_ff == '0) begin
                        stat_in = ST_IGNORED;
                     end else begin
                        n_in = n_ff - 1'b1;
                     end
                  end
                  OP_CLEAR:  n_in   = '0;
                  OP_LENGTH: res_in = 32'(n_ff);
                  OP_COUNT: begin
                     if (n_ff != '0) begin
                        idx_in   = '0;
                        state_in = S_CNT_RD;
                     end
                  end
                  OP_REVERSE: begin
                     if (nx > XW'(1)) begin
                        idx_in   = '0;
                        b_in     = n_ff - 1'b1;
                        state_in = S_P_RDA;
                     end
                  end
                  OP_SET: begin
                     if (px < nx) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(px);
                        ram_wdata = cmd.value;
                     end else begin
                        stat_in = ST_IGNORED;
                     end
                  end
                  OP_GET: begin
                     if (px < nx) begin
                        ram_raddr = AW'(px);
                        state_in  = S_GET_WT;
                     end else begin
                        res_in  = -32'sd1;
                        stat_in = ST_IGNORED;
                     end
                  end
                  OP_ERASE: begin
                     if (px >= nx) begin
                        stat_in = ST_IGNORED;
                     end else if (px + XW'(1) == nx) begin
                        n_in = n_ff - 1'b1;
                     end else begin
                        idx_in   = CW'(px);
                        state_in = S_SH_RD;
                     end
                  end
                  OP_SWAP: begin
                     if (px + XW'(1) < nx) begin
                        idx_in   = CW'(px);
                        b_in     = CW'(px + XW'(1));
                        state_in = S_P_RDA;
                     end else begin
                        stat_in = ST_IGNORED;
                     end
                  end
                  OP_SORT: begin
                     if (nx > XW'(1)) begin
                        idx_in   = '0;
                        b_in     = CW'(1);
                        lim_in   = n_ff - 1'b1;
                        state_in = S_P_RDA;
                     end
                  end
                  default: stat_in = ST_IGNORED;
               endcase
            end
         end
         S_SH_RD: begin
            ram_raddr = (cmd_ff.op == OP_INSERT) ? AW'(ix - XW'(1)) : AW'(ix + XW'(1));
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (cmd_ff.op == OP_INSERT) begin
               idx_in   = idx_ff - 1'b1;
               state_in = (ix - XW'(1) == cpx) ? S_INS_FIN : S_SH_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (ix + XW'(2) == nx) begin
                  n_in     = n_ff - 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SH_RD;
               end
            end
         end
         S_INS_FIN: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cpx);
            ram_wdata = cmd_ff.value;
            n_in      = n_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_CNT_RD: state_in = S_CNT_CMP;
         S_CNT_CMP: begin
            if (ram_rdata == cmd_ff.value) begin
               res_in = res_ff + 32'sd1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = (ix + XW'(1) == nx) ? S_DONE : S_CNT_RD;
         end
         S_GET_WT: begin
            res_in   = ram_rdata;
            state_in = S_DONE;
         end
         S_P_RDA: state_in = S_P_RDB;
         S_P_RDB: begin
            ram_raddr = b_ff[AW-1:0];
            da_in     = ram_rdata;
            state_in  = S_P_CMP;
         end
         S_P_CMP: begin
            db_in = ram_rdata;
            if (cmd_ff.op != OP_SORT || $signed(ram_rdata) < $signed(da_ff)) begin
               state_in = S_P_WRA;
            end else begin
               state_in = S_P_NEXT;
            end
         end
         S_P_WRA: begin
            ram_we    = 1'b1;
            ram_wdata = db_ff;
            state_in  = S_P_WRB;
         end
         S_P_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = b_ff[AW-1:0];
            ram_wdata = da_ff;
            state_in  = S_P_NEXT;
         end
         S_P_NEXT: begin
            state_in = S_DONE;
            if (cmd_ff.op == OP_REVERSE) begin
               if (ix + XW'(1) < bx - XW'(1)) begin
                  idx_in   = idx_ff + 1'b1;
                  b_in     = b_ff - 1'b1;
                  state_in = S_P_RDA;
               end
            end else if (cmd_ff.op == OP_SORT) begin
               if (ix + XW'(1) < XW'(lim_ff)) begin
                  idx_in   = idx_ff + 1'b1;
                  b_in     = b_ff + 1'b1;
                  state_in = S_P_RDA;
               end else if (lim_ff != CW'(1)) begin
                  lim_in   = lim_ff - 1'b1;
                  idx_in   = '0;
                  b_in     = CW'(1);
                  state_in = S_P_RDA;
               end
            end
         end
         S_DONE: begin
            if (!out_valid_ff || pop) begin
               out_in.result_value = res_ff;
               out_in.list_length  = nx[8:0];
               out_in.status       = stat_ff;
               out_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      b_ff    <= b_in;
      lim_ff  <= lim_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
      out_ff  <= out_in;
   end

endmodule

@@ src/indexed_list_engine_core.sv @@
// Indexed list engine: append, pop, clear, length, set, get and rejected requests touch
// at most one entry; insert and erase move entries one by one, count reads every entry,
// swap and reverse read and write each pair, and sort makes n*(n-1)/2 compares and swaps
// a pair only when it is out of order. One request runs at a time; the next starts once the
// previous result is registered, and its result waits in S_DONE until that one is popped.
// Reset empties the list and both queues at once; entries hold stale data, no sweep.
// Depends on ile_pkg, ile_front, ile_back and ile_ram.
module indexed_list_engine_core
   import ile_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   // Request side: a beat is taken when push is high and full is low.
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   // Result side: a beat leaves when pop is high and empty is low.
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);

   // The front end queues up to two classified commands, so a new request
   // beat can be taken while the back end is still walking the list.
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;

   // Element store port signals between the sequencer and the RAM.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [31:0]   ram_rdata;

   ile_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // The back end owns the element count and the result register, and runs
   // one command at a time through its sequencer.
   ile_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   ile_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
